FILE: hdl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg: shared constants for the prefix code bit packer
// Field widths, item kind codes, codebook depth and job queue depth.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  // Input and result field widths
  localparam int KIND_W   = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 48;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;

  // Codebook depth, one entry per byte symbol
  localparam int SYM_COUNT = 256;

  // Entries in the job queue between front and back
  localparam int Q_DEPTH = 4;

  // Item kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

endpackage

FILE: hdl/pcbp_front.sv
// ----------------------------------------------------------------------------
// pcbp_front: item intake, codebook lookup and bit merge
// Writes codebook entries, looks up codewords, merges them with the pending
// bits and hands each item's complete bytes to the back as one job.
// ----------------------------------------------------------------------------
module pcbp_front #(
  parameter int  MAX_CODE_LEN = 48,
  localparam int ACC_W        = MAX_CODE_LEN + 7,
  localparam int SH_W         = $clog2(ACC_W),
  localparam int NB_W         = $clog2(ACC_W / 8 + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pcbp_pkg::KIND_W-1:0]  in_kind,
  input  logic [pcbp_pkg::SYM_W-1:0]   in_symbol,
  input  logic [pcbp_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [pcbp_pkg::LEN_W-1:0]   in_code_length,
  output logic                         job_valid,
  input  logic                         job_ready,
  output logic [ACC_W-1:0]             job_acc,
  output logic [SH_W-1:0]              job_shift,
  output logic [NB_W-1:0]              job_count
);
  import pcbp_pkg::*;

  localparam int STORE_W = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int TOT_W   = $clog2(ACC_W + 1);

  // Codebook storage
  logic [STORE_W-1:0]   code_mem [SYM_COUNT];
  logic [LEN_W-1:0]     len_mem  [SYM_COUNT];
  logic [SYM_COUNT-1:0] len_vld_r;
  logic [STORE_W-1:0]   rd_code_r;
  logic [LEN_W-1:0]     rd_len_r;
  logic                 rd_vld_r;

  // Lookup stage and pending bits
  logic                 a_v_r;
  logic                 a_flush_r;
  logic [6:0]           pend_bits_r, pend_bits_nxt;
  logic [2:0]           pend_cnt_r, pend_cnt_nxt;

  logic                 in_fire;
  logic                 in_work;
  logic                 b_go;
  logic                 has_bytes;
  logic [LEN_W-1:0]     ld_len;
  logic [LEN_W-1:0]     clen;
  logic [ACC_W-1:0]     code_ext;
  logic [ACC_W-1:0]     code_mask;
  logic [ACC_W-1:0]     acc;
  logic [TOT_W-1:0]     total;
  logic [2:0]           rem;
  logic [NB_W-1:0]      enc_nb;
  logic [6:0]           enc_pend;
  logic [2:0]           fl_sh;
  logic [7:0]           fl_byte;

  assign in_fire = in_valid && in_ready;

  // Classify: only encode and flush beats go on to the merge stage
  always_comb begin
    in_work = 1'b0;
    if (in_kind inside {KIND_ENCODE, KIND_FLUSH}) begin
      in_work = 1'b1;
    end
  end

  // Saturate overlong lengths on load
  assign ld_len = (in_code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : in_code_length;

  // Write codebook on load, read it on every accepted beat
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == KIND_LOAD)) begin
      code_mem[in_symbol] <= in_code_bits[STORE_W-1:0];
      len_mem[in_symbol]  <= ld_len;
    end
    if (in_fire) begin
      rd_code_r <= code_mem[in_symbol];
      rd_len_r  <= len_mem[in_symbol];
      rd_vld_r  <= len_vld_r[in_symbol];
    end
  end

  // Mark lengths written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (in_fire && (in_kind == KIND_LOAD)) begin
      len_vld_r[in_symbol] <= 1'b1;
    end
  end

  // Merge codeword with pending bits
  assign clen      = rd_vld_r ? rd_len_r : '0;
  assign code_ext  = {{(ACC_W - STORE_W){1'b0}}, rd_code_r};
  assign code_mask = (ACC_W'(1) << clen) - ACC_W'(1);
  assign acc       = (ACC_W'(pend_bits_r) << clen) | (code_ext & code_mask);
  assign total     = TOT_W'(pend_cnt_r) + TOT_W'(clen);
  assign rem       = total[2:0];
  assign enc_nb    = NB_W'(total >> 3);
  assign enc_pend  = acc[6:0] & ((7'(1) << rem) - 7'(1));

  // Flush: leftover bits to the top of one byte
  assign fl_sh   = 3'(4'd8 - {1'b0, pend_cnt_r});
  assign fl_byte = {1'b0, pend_bits_r} << fl_sh;

  // Build the job and the next pending state
  always_comb begin
    job_acc       = acc;
    job_shift     = SH_W'(total - TOT_W'(8));
    job_count     = enc_nb;
    pend_bits_nxt = enc_pend;
    pend_cnt_nxt  = rem;
    has_bytes     = (enc_nb != '0);
    if (a_flush_r) begin
      job_acc       = ACC_W'(fl_byte);
      job_shift     = '0;
      job_count     = NB_W'(1);
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
      has_bytes     = (pend_cnt_r != '0);
    end
  end

  // Advance when the job is taken or there is nothing to send
  assign job_valid = a_v_r && has_bytes;
  assign b_go      = a_v_r && (job_ready || !has_bytes);
  assign in_ready  = !a_v_r || b_go;

  // Hold the lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ready) begin
      a_v_r <= in_fire && in_work;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_flush_r <= (in_kind == KIND_FLUSH);
    end
  end

  // Update pending bits as each item leaves the merge stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (b_go) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

FILE: hdl/pcbp_fifo.sv
// ----------------------------------------------------------------------------
// pcbp_fifo: job queue between front and back
// Small register queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module pcbp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import pcbp_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PTR_W:0]   wr_ptr_r;
  logic [PTR_W:0]   rd_ptr_r;
  logic             full;
  logic             empty;

  assign empty      = (wr_ptr_r == rd_ptr_r);
  assign full       = (wr_ptr_r[PTR_W] != rd_ptr_r[PTR_W]) &&
                      (wr_ptr_r[PTR_W-1:0] == rd_ptr_r[PTR_W-1:0]);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_data   = mem_r[rd_ptr_r[PTR_W-1:0]];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      mem_r[wr_ptr_r[PTR_W-1:0]] <= push_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push_valid && push_ready) begin
        wr_ptr_r <= wr_ptr_r + (PTR_W+1)'(1);
      end
      if (pop_valid && pop_ready) begin
        rd_ptr_r <= rd_ptr_r + (PTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/pcbp_back.sv
// ----------------------------------------------------------------------------
// pcbp_back: byte emitter
// Takes one job at a time and sends its bytes, earliest first, one beat per
// cycle while out_ready is high, flagging the final byte of each job.
// ----------------------------------------------------------------------------
module pcbp_back #(
  parameter int  MAX_CODE_LEN = 48,
  localparam int ACC_W        = MAX_CODE_LEN + 7,
  localparam int SH_W         = $clog2(ACC_W),
  localparam int NB_W         = $clog2(ACC_W / 8 + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  logic [ACC_W-1:0]             job_acc,
  input  logic [SH_W-1:0]              job_shift,
  input  logic [NB_W-1:0]              job_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcbp_pkg::BYTE_W-1:0]  out_out_byte,
  output logic                         out_last
);
  import pcbp_pkg::*;

  logic             cur_v_r;
  logic [ACC_W-1:0] acc_r;
  logic [SH_W-1:0]  sh_r;
  logic [NB_W-1:0]  left_r;
  logic             on_last;

  assign on_last      = (left_r == NB_W'(1));
  assign out_valid    = cur_v_r;
  assign out_last     = on_last;
  assign out_out_byte = BYTE_W'(acc_r >> sh_r);
  assign job_ready    = !cur_v_r || (out_ready && on_last);

  // Hold the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (job_ready) begin
      cur_v_r <= job_valid;
    end
  end

  // Load a new job or step to the next byte
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      acc_r  <= job_acc;
      sh_r   <= job_shift;
      left_r <= job_count;
    end else if (cur_v_r && out_ready) begin
      sh_r   <= sh_r - SH_W'(8);
      left_r <= left_r - NB_W'(1);
    end
  end

endmodule

FILE: hdl/prefix_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_top: prefix code bit packer, byte stream out
// Loads a codebook per byte symbol, packs codewords MSB first into bytes and
// pads leftover bits on flush.
// ----------------------------------------------------------------------------
// The block takes one input beat every cycle while not stalled. Load beats
// write the codebook at once; encode and flush beats pass a registered
// codebook read and a bit merge stage, then the job queue and the byte
// emitter's job register before the first byte of an item shows. The result
// side sends one byte per cycle while out_ready is high; a four-entry job
// queue between the merge stage and the byte emitter absorbs bursts, and
// input stalls only once that queue is full. The length table has a valid
// bit per symbol that reset clears; no clearing pass is needed.
module prefix_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pcbp_pkg::KIND_W-1:0]  in_kind,
  input  logic [pcbp_pkg::SYM_W-1:0]   in_symbol,
  input  logic [pcbp_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [pcbp_pkg::LEN_W-1:0]   in_code_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcbp_pkg::BYTE_W-1:0]  out_out_byte,
  output logic                         out_last
);
  import pcbp_pkg::*;

  localparam int ACC_W = MAX_CODE_LEN + 7;
  localparam int SH_W  = $clog2(ACC_W);
  localparam int NB_W  = $clog2(ACC_W / 8 + 1);
  localparam int JOB_W = ACC_W + SH_W + NB_W;

  logic             f_valid, f_ready;
  logic [ACC_W-1:0] f_acc;
  logic [SH_W-1:0]  f_shift;
  logic [NB_W-1:0]  f_count;
  logic             b_valid, b_ready;
  logic [JOB_W-1:0] b_job;

  pcbp_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .job_valid      (f_valid),
    .job_ready      (f_ready),
    .job_acc        (f_acc),
    .job_shift      (f_shift),
    .job_count      (f_count)
  );

  pcbp_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_acc, f_shift, f_count}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  pcbp_back #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (b_valid),
    .job_ready    (b_ready),
    .job_acc      (b_job[JOB_W-1 -: ACC_W]),
    .job_shift    (b_job[NB_W +: SH_W]),
    .job_count    (b_job[NB_W-1:0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

endmodule

FILE: hdl/pcbp_checker.sv
// ----------------------------------------------------------------------------
// pcbp_checker: port-level checks for the prefix code bit packer
// Watches the top level's ports over time; attached by bind.
// ----------------------------------------------------------------------------
module pcbp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pcbp_pkg::BYTE_W-1:0]  out_out_byte,
  input logic                         out_last
);
  import pcbp_pkg::*;

  // Reset empties the result side
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  // An empty result side never back-pressures the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

endmodule

bind prefix_code_bit_packer_top pcbp_checker u_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the prefix code bit packer
// Loads codebooks, streams encode and flush beats under random idling on both
// sides, and compares every packed byte and its last flag with a local packer.
// ----------------------------------------------------------------------------
module tb;
  import pcbp_pkg::*;

  localparam int MAX_LEN     = 48;
  localparam int HALF_PERIOD = 6;
  localparam int RAND_ITEMS  = 280;
  localparam int POOL_SIZE   = 32;
  // Kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_byte_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind        = '0;
  logic [SYM_W-1:0]    in_symbol      = '0;
  logic [CODE_W-1:0]   in_code_bits   = '0;
  logic [LEN_W-1:0]    in_code_length = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [BYTE_W-1:0]   out_out_byte;
  logic                out_last;

  // Local copy of the codebook and the leftover bits
  logic [CODE_W-1:0]   cw_tbl  [SYM_COUNT];
  logic [LEN_W-1:0]    len_tbl [SYM_COUNT];
  logic [6:0]          pend_bits;
  int                  pend_cnt;

  packed_byte_t        owed_bytes[$];
  logic [SYM_W-1:0]    pool [POOL_SIZE];
  bit                  steady = 1'b0;
  int                  err_cnt   = 0;
  int                  n_beats   = 0;
  int                  n_bytes   = 0;
  int                  n_six     = 0;
  int                  n_padded  = 0;

  prefix_code_bit_packer_top #(
    .MAX_CODE_LEN (MAX_LEN)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_last       (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 15);
  end

  // Work out the bytes one accepted beat owes and advance the packer state
  task automatic predict_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    logic [63:0]  acc;
    int           clen;
    int           total;
    int           nbytes;
    int           rem;
    packed_byte_t b;
    case (kind)
      KIND_LOAD: begin
        cw_tbl[sym]  = code;
        len_tbl[sym] = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
      end
      KIND_ENCODE: begin
        clen = len_tbl[sym];
        if (clen != 0) begin
          acc = (64'(pend_bits) << clen) | (64'(cw_tbl[sym]) & ((64'd1 << clen) - 64'd1));
          total  = pend_cnt + clen;
          nbytes = total / 8;
          rem    = total % 8;
          for (int k = 0; k < nbytes; k++) begin
            b.value = BYTE_W'(acc >> (total - 8 * (k + 1)));
            b.last  = (k == nbytes - 1);
            owed_bytes.push_back(b);
          end
          pend_bits = 7'(acc & ((64'd1 << rem) - 64'd1));
          pend_cnt  = rem;
          if (nbytes == 6) n_six++;
        end
      end
      KIND_FLUSH: begin
        // Pad leftover bits with zeros in the low positions
        if (pend_cnt != 0) begin
          b.value = BYTE_W'(16'(pend_bits) << (8 - pend_cnt));
          b.last  = 1'b1;
          owed_bytes.push_back(b);
          pend_bits = '0;
          pend_cnt  = 0;
          n_padded++;
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat, hold it until accepted, then predict its bytes
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_symbol      <= sym;
    in_code_bits   <= code;
    in_code_length <= len;
    do @(posedge clk); while (!in_ready);
    n_beats++;
    predict_item(kind, sym, code, len);
  endtask

  task automatic wait_drain();
    while (owed_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'({$urandom(), $urandom()});
  endfunction

  // Mostly short codewords, some long, a few overlong and a few unused
  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return LEN_W'($urandom_range(1, 10));
    if (r < 80) return LEN_W'($urandom_range(11, 32));
    if (r < 92) return LEN_W'($urandom_range(33, 48));
    if (r < 97) return LEN_W'($urandom_range(49, 63));
    return '0;
  endfunction

  // Check each accepted byte against the oldest owed byte
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_bytes.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected byte, expected none, actual %02h last %0b",
                 $time, out_out_byte, out_last);
      end else begin
        want = owed_bytes.pop_front();
        n_bytes++;
        if (out_out_byte !== want.value) begin
          err_cnt++;
          $display("%0t ns: out_byte mismatch, expected %02h, actual %02h",
                   $time, want.value, out_out_byte);
        end
        if (out_last !== want.last) begin
          err_cnt++;
          $display("%0t ns: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_last);
        end
      end
    end
  end

  // Encodes and flushes straight after reset find an empty length table
  task automatic test_cleared_table();
    send_item(KIND_ENCODE, 8'h00, rand_code(), 6'd48);
    send_item(KIND_ENCODE, 8'hFF, rand_code(), 6'd63);
    send_item(KIND_FLUSH,  8'h00, '0, '0);
  endtask

  // Field extremes, saturation, unused entries, ignored kind, padded flushes
  task automatic test_directed_codes();
    send_item(KIND_LOAD,   8'h00, 48'hFFFF_FFFF_FFFF, 6'd48);
    send_item(KIND_LOAD,   8'hFF, 48'hFFFF_FFFF_FFFE, 6'd1);
    send_item(KIND_LOAD,   8'h5A, 48'hA5A5_5A5A_C3C3, 6'd63);
    send_item(KIND_LOAD,   8'h3C, 48'h0000_0000_007F, 6'd7);
    send_item(KIND_LOAD,   8'h11, 48'h1234_5678_9ABC, 6'd0);
    send_item(KIND_LOAD,   8'h01, 48'h8000_0001_2345, 6'd32);
    send_item(KIND_NONE,   8'h00, 48'hFFFF_FFFF_FFFF, 6'd48);
    send_item(KIND_ENCODE, 8'h3C, '0, '0);
    send_item(KIND_ENCODE, 8'h00, '0, '0);
    send_item(KIND_ENCODE, 8'h5A, '0, '0);
    send_item(KIND_ENCODE, 8'h11, '0, '0);
    send_item(KIND_FLUSH,  8'hFF, 48'hFFFF_FFFF_FFFF, 6'd63);
    send_item(KIND_FLUSH,  8'h00, '0, '0);
    send_item(KIND_ENCODE, 8'hFF, '0, '0);
    send_item(KIND_FLUSH,  8'h00, '0, '0);
    send_item(KIND_ENCODE, 8'h00, '0, '0);
    send_item(KIND_FLUSH,  8'h00, '0, '0);
    send_item(KIND_ENCODE, 8'h01, '0, '0);
    send_item(KIND_ENCODE, 8'hFF, '0, '0);
    send_item(KIND_ENCODE, 8'h3C, '0, '0);
    send_item(KIND_FLUSH,  8'h00, '0, '0);
  endtask

  // Fill the job queue with six-byte encodes, then hold off until all drain
  task automatic test_drain_pause();
    steady = 1'b1;
    send_item(KIND_ENCODE, 8'h3C, '0, '0);
    repeat (6) send_item(KIND_ENCODE, 8'h00, '0, '0);
    steady = 1'b0;
    in_valid <= 1'b0;
    wait_drain();
    send_item(KIND_FLUSH, 8'h00, '0, '0);
  endtask

  // Random codebook, then mostly encodes from it with reloads, flushes, noise
  task automatic test_random_stream();
    int            sent;
    int            r;
    int            slot;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = SYM_W'($urandom_range(0, 255));
      send_item(KIND_LOAD, pool[i], rand_code(), rand_len());
    end
    sent = 0;
    while (sent < RAND_ITEMS) begin
      steady = (sent >= 120 && sent < 200);
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_item(KIND_ENCODE, pool[$urandom_range(0, POOL_SIZE - 1)], rand_code(),
                  LEN_W'($urandom_range(0, 63)));
      end else if (r < 70) begin
        send_item(KIND_ENCODE, SYM_W'($urandom_range(0, 255)), rand_code(),
                  LEN_W'($urandom_range(0, 63)));
      end else if (r < 80) begin
        send_item(KIND_FLUSH, SYM_W'($urandom_range(0, 255)), rand_code(),
                  LEN_W'($urandom_range(0, 63)));
      end else if (r < 93) begin
        // Reload a pool entry, now and then swapping in a fresh symbol
        slot = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 2) == 0) pool[slot] = SYM_W'($urandom_range(0, 255));
        len = rand_len();
        send_item(KIND_LOAD, pool[slot], rand_code(), len);
      end else begin
        send_item(KIND_NONE, SYM_W'($urandom_range(0, 255)), rand_code(),
                  LEN_W'($urandom_range(0, 63)));
        continue;
      end
      sent++;
    end
    steady = 1'b0;
    send_item(KIND_FLUSH, 8'h00, '0, '0);
    in_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SYM_COUNT; i++) begin
      cw_tbl[i]  = '0;
      len_tbl[i] = '0;
    end
    pend_bits = '0;
    pend_cnt  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_table();
    test_directed_codes();
    test_drain_pause();
    test_random_stream();
    wait_drain();
    // Allow time for any stray byte from a beat that owed nothing
    repeat (20) @(posedge clk);
    if (owed_bytes.size() != 0) begin
      err_cnt++;
      $display("%0t ns: %0d bytes never arrived", $time, owed_bytes.size());
    end
    $display("run covered %0d beats and %0d checked bytes with random idling on both sides",
             n_beats, n_bytes);
    $display("including %0d six-byte encodes and %0d padded flushes", n_six, n_padded);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("timeout with %0d bytes still owed", owed_bytes.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: prefix_code_bit_packer_top.f
hdl/pcbp_pkg.sv
hdl/pcbp_front.sv
hdl/pcbp_fifo.sv
hdl/pcbp_back.sv
hdl/prefix_code_bit_packer_top.sv
hdl/pcbp_checker.sv
verif/tb.sv
